FILE: rtl/ptb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptb_pkg;

  typedef enum logic [1:0] {
    REQ_INIT  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_TICK  = 2'd3
  } ptb_req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_PARAM = 2'd1,
    ST_NOT_INIT  = 2'd2
  } ptb_status_t;

  localparam int PERIOD_W = 23;
  localparam int COUNT_W  = 32;
  localparam int MASK_W   = 4;

  // ceil(us / 1000) = floor((us + 999) / 8 / 125); n / 125 is exact for n < 2^30
  // as floor(n * ceil(2^37 / 125) / 2^37)
  localparam logic [32:0] ROUND_UP   = 33'd999;
  localparam logic [30:0] DIV_RECIP  = 31'd1099511628;
  localparam int          DIV_SHIFT  = 37;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  timer_sel;
    logic [31:0] period_usec;
    logic        underflow_flag;
  } ptb_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [MASK_W-1:0] fired_mask;
    logic [31:0]       tick_now;
  } ptb_out_t;

endpackage

`default_nettype wire

FILE: rtl/periodic_timer_bank_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Bank of NUM_TIMERS periodic millisecond timers on a 32-bit ms counter.
// Each request (init, start, stop, tick) yields exactly one result item with
// a status, a mask of the timers that fired on a tick (timers 0..3 only) and
// the counter value after the request. An item is held in the input
// register, is resolved in a single combinational pass (ms rounding through
// one reciprocal multiply, parallel expiry compares) and lands in the output
// register; one item is taken every cycle while results are being drained.

module periodic_timer_bank_unit #(
  parameter int NUM_TIMERS = 4
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire ptb_pkg::ptb_in_t in_data,
  output logic             out_valid,
  input  wire              out_ready,
  output ptb_pkg::ptb_out_t out_data
);

  import ptb_pkg::*;

  localparam int FIRE_W = (NUM_TIMERS > MASK_W) ? NUM_TIMERS : MASK_W;

  logic    in_valid_r;
  ptb_in_t in_r;
  logic    out_valid_r;
  ptb_out_t out_r;
  logic    move;

  logic [COUNT_W-1:0]  ms_r, ms_nxt;
  logic [NUM_TIMERS-1:0] init_r, init_nxt;
  logic [NUM_TIMERS-1:0] run_r, run_nxt;
  logic [PERIOD_W-1:0] per_r   [NUM_TIMERS];
  logic [PERIOD_W-1:0] per_nxt [NUM_TIMERS];
  logic [COUNT_W-1:0]  exp_r   [NUM_TIMERS];
  logic [COUNT_W-1:0]  exp_nxt [NUM_TIMERS];

  logic [32:0]         us_round;
  logic [60:0]         prod;
  logic [PERIOD_W-1:0] pms;
  logic [NUM_TIMERS-1:0] hit;
  logic                id_ok;
  logic                sel_init;
  logic                is_tick;
  logic [FIRE_W-1:0]   fire_all;
  ptb_out_t            res;

  assign move      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || move;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign us_round = {1'b0, in_r.period_usec} + ROUND_UP;
  assign prod     = 61'(us_round[32:3]) * 61'(DIV_RECIP);
  assign pms      = prod[DIV_SHIFT+PERIOD_W-1:DIV_SHIFT];

  assign is_tick = (in_r.req_type == REQ_TICK);
  assign id_ok   = (32'(in_r.timer_sel) < NUM_TIMERS);

  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      hit[i] = (32'(in_r.timer_sel) == i);
    end
  end

  assign sel_init = |(init_r & hit);

  always_comb begin
    ms_nxt   = ms_r;
    init_nxt = init_r;
    run_nxt  = run_r;
    per_nxt  = per_r;
    exp_nxt  = exp_r;
    fire_all = '0;
    res.status     = ST_OK;
    res.fired_mask = '0;

    if (is_tick) begin
      ms_nxt = ms_r + COUNT_W'(in_r.underflow_flag);
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (run_r[i] && (ms_nxt >= exp_r[i])) begin
          exp_nxt[i]  = ms_nxt + COUNT_W'(per_r[i]);
          fire_all[i] = 1'b1;
        end
      end
    end else if (!id_ok) begin
      res.status = ST_BAD_PARAM;
    end else if (in_r.req_type == REQ_INIT) begin
      if (in_r.period_usec == '0) begin
        res.status = ST_BAD_PARAM;
      end else begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (hit[i]) begin
            init_nxt[i] = 1'b1;
            run_nxt[i]  = 1'b0;
            per_nxt[i]  = pms;
            exp_nxt[i]  = ms_r + COUNT_W'(pms);
          end
        end
      end
    end else if (!sel_init) begin
      res.status = ST_NOT_INIT;
    end else if (in_r.req_type == REQ_START) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (hit[i]) begin
          run_nxt[i] = 1'b1;
          exp_nxt[i] = ms_r + COUNT_W'(per_r[i]);
        end
      end
    end else begin
      run_nxt = run_r & ~hit;
    end

    res.fired_mask = fire_all[MASK_W-1:0];
    res.tick_now   = ms_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ms_r        <= '0;
      init_r      <= '0;
      run_r       <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        per_r[i] <= '0;
        exp_r[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (move) begin
        ms_r   <= ms_nxt;
        init_r <= init_nxt;
        run_r  <= run_nxt;
        per_r  <= per_nxt;
        exp_r  <= exp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
    if (move) begin
      out_r <= res;
    end
  end

endmodule

`default_nettype wire
